>>> hdl/policy_selectable_job_queue_defines.svh
// Assertion macros for the policy-selectable job queue.
// Included by the top level; no other dependencies.
`ifndef POLICY_SELECTABLE_JOB_QUEUE_DEFINES_SVH
`define POLICY_SELECTABLE_JOB_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define PSJQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define PSJQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PSJQ_ASSERT_NOW(lbl, ante, cons, msg)
`define PSJQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> hdl/psjq_pkg.sv
// Shared types, widths and codes for the policy-selectable job queue.
// No dependencies.
`timescale 1ns / 1ps

package psjq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int TAG_W  = 8;
  localparam int ARR_W  = 32;
  localparam int EXP_W  = 16;
  localparam int PRI_W  = 8;
  localparam int QCNT_W = 7;
  localparam int TOT_W  = 16;
  localparam int POL_W  = 2;
  localparam int KEY_W  = 32;

  // Keys below this rank after every key at or above it.
  localparam int KEY_FLOOR = 1;

  localparam logic KIND_SUBMIT   = 1'b0;
  localparam logic KIND_DISPATCH = 1'b1;

  localparam logic [POL_W-1:0] POL_FCFS = 2'd0;
  localparam logic [POL_W-1:0] POL_SJF  = 2'd1;
  localparam logic [POL_W-1:0] POL_PRIO = 2'd2;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [ARR_W-1:0] arrival;
    logic [EXP_W-1:0] runtime;
    logic [PRI_W-1:0] prio;
  } slot_entry_t;

  // Lexicographic rank, smaller is served first.
  typedef struct packed {
    logic             late;
    logic [KEY_W-1:0] key;
    logic [ARR_W-1:0] arrival;
  } rank_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB_SCAN,
    ST_DSP_SCAN,
    ST_DSP_LAST,
    ST_DSP_COMMIT,
    ST_FINISH
  } psjq_state_t;

endpackage

>>> hdl/psjq_if.sv
// Valid/ready channel interfaces for job items and result items.
// Depends on psjq_pkg.
`timescale 1ns / 1ps

interface psjq_in_if import psjq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [TAG_W-1:0] job_tag;
  logic [ARR_W-1:0] arrival_stamp;
  logic [EXP_W-1:0] expected_time;
  logic [PRI_W-1:0] job_priority;

  modport source (output valid, kind, job_tag, arrival_stamp, expected_time, job_priority,
                  input ready);
  modport sink   (input valid, kind, job_tag, arrival_stamp, expected_time, job_priority,
                  output ready);
endinterface

interface psjq_out_if import psjq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              accepted;
  logic              dispatch_valid;
  logic [TAG_W-1:0]  out_tag;
  logic [EXP_W-1:0]  out_expected;
  logic [PRI_W-1:0]  out_priority;
  logic [QCNT_W-1:0] queue_count;
  logic [TOT_W-1:0]  submitted_total;

  modport source (output valid, accepted, dispatch_valid, out_tag, out_expected,
                  out_priority, queue_count, submitted_total, input ready);
  modport sink   (input valid, accepted, dispatch_valid, out_tag, out_expected,
                  out_priority, queue_count, submitted_total, output ready);
endinterface

>>> hdl/psjq_rank_unit.sv
// Rank former and comparator shared by every step of the dispatch scan.
// Depends on psjq_pkg.
`timescale 1ns / 1ps

module psjq_rank_unit import psjq_pkg::*; (
  input  logic [POL_W-1:0] policy,
  input  slot_entry_t      cand,
  input  rank_t            best,
  output rank_t            cand_rank,
  output logic             better
);

  logic [KEY_W-1:0] key;

  always_comb begin
    case (policy)
      POL_FCFS: key = KEY_W'(cand.arrival);
      POL_SJF:  key = KEY_W'(cand.runtime);
      POL_PRIO: key = KEY_W'(cand.prio);
      default:  key = KEY_W'(cand.arrival);
    endcase
  end

  // Zero keys go to the back; equal keys fall back on arrival.
  assign cand_rank.late    = (key < KEY_W'(KEY_FLOOR));
  assign cand_rank.key     = key;
  assign cand_rank.arrival = cand.arrival;

  // Strict compare: on a full tie the earlier slot, already held, stays.
  assign better = (cand_rank < best);

endmodule

>>> hdl/policy_selectable_job_queue.sv
// Top level of the policy-selectable job queue: slot memory, sequencer, result register.
// Depends on psjq_pkg, psjq_if, psjq_rank_unit and policy_selectable_job_queue_defines.svh.
//
// Holds up to QUEUE_DEPTH jobs (64) in a single-port slot memory with one valid flip-flop
// per slot. A submit beat stores the job in the lowest free slot and returns accepted = 1,
// or accepted = 0 at once when the table is full. A dispatch beat walks every slot, one per
// cycle, through one rank comparator and removes the best job under order_policy
// (0 earliest arrival, 1 shortest run time, 2 lowest priority number, 3 as 0); a zero key
// ranks last and ties go to the earlier arrival, then the lower slot. Every input beat gives
// exactly one result beat. Timing: one item is worked on at a time and in_ch.ready is high
// only while idle. A dispatch runs from acceptance through the slot scan, a last compare
// for the registered memory read, a commit and the result load, and the next beat is taken
// once the result is loaded and the sequencer is back in idle. A submit probes the slots
// from slot 0 up to the first free one before its result load; a refused submit or a
// dispatch on an empty queue goes straight to the result load. The result sits in an output
// register, so a stalled sink holds only the next item's result load, not the scan.
// order_policy is written through cfg_we / cfg_data and must only change while idle.
`timescale 1ns / 1ps
`include "policy_selectable_job_queue_defines.svh"

module policy_selectable_job_queue import psjq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [POL_W-1:0] cfg_data,
  psjq_in_if.sink          in_ch,
  psjq_out_if.source       out_ch
);

  // Sequencer state and decoded controls.
  psjq_state_t state_r, state_nxt;
  logic in_ready_c, scan_rd_c, sub_probe_c, sub_hit_c, dsp_cmp_c, dsp_commit_c, fin_c;
  logic in_beat, out_free;

  // Control registers.
  logic [POL_W-1:0]       policy_r;
  logic [QUEUE_DEPTH-1:0] valid_r;
  logic [CNT_W-1:0]       count_r;
  logic [TOT_W-1:0]       submitted_r;
  logic [IDX_W-1:0]       cnt_r;
  logic                   rd_live_r;
  logic                   best_found_r;
  logic                   res_acc_r;
  logic                   res_dv_r;
  logic                   out_valid_r;

  // Payload registers.
  slot_entry_t            slot_mem_r [QUEUE_DEPTH];
  slot_entry_t            job_r;
  slot_entry_t            rd_data_r;
  logic [IDX_W-1:0]       rd_idx_r;
  rank_t                  best_rank_r;
  logic [IDX_W-1:0]       best_idx_r;
  slot_entry_t            best_job_r;
  logic                   out_acc_r;
  logic                   out_dv_r;
  logic [TAG_W-1:0]       out_tag_r;
  logic [EXP_W-1:0]       out_exp_r;
  logic [PRI_W-1:0]       out_pri_r;
  logic [QCNT_W-1:0]      out_qcnt_r;
  logic [TOT_W-1:0]       out_tot_r;

  rank_t cand_rank;
  logic  cand_better;
  logic  take_cand;
  logic  q_full, q_empty, scan_end;

  assign q_full   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_empty  = (count_r == '0);
  assign scan_end = (cnt_r == IDX_W'(QUEUE_DEPTH - 1));
  assign in_beat  = in_ch.valid && in_ready_c;
  assign out_free = !out_valid_r || out_ch.ready;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          if (in_ch.kind == KIND_DISPATCH) begin
            state_nxt = q_empty ? ST_FINISH : ST_DSP_SCAN;
          end else begin
            state_nxt = q_full ? ST_FINISH : ST_SUB_SCAN;
          end
        end
      end
      ST_SUB_SCAN: begin
        if (!valid_r[cnt_r]) state_nxt = ST_FINISH;
      end
      ST_DSP_SCAN: begin
        if (scan_end) state_nxt = ST_DSP_LAST;
      end
      ST_DSP_LAST:   state_nxt = ST_DSP_COMMIT;
      ST_DSP_COMMIT: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- decoded controls
  always_comb begin
    in_ready_c   = 1'b0;
    scan_rd_c    = 1'b0;
    sub_probe_c  = 1'b0;
    dsp_cmp_c    = 1'b0;
    dsp_commit_c = 1'b0;
    fin_c        = 1'b0;
    case (state_r)
      ST_IDLE:       in_ready_c   = 1'b1;
      ST_SUB_SCAN:   sub_probe_c  = 1'b1;
      ST_DSP_SCAN: begin
        scan_rd_c = 1'b1;
        dsp_cmp_c = 1'b1;
      end
      ST_DSP_LAST:   dsp_cmp_c    = 1'b1;
      ST_DSP_COMMIT: dsp_commit_c = 1'b1;
      ST_FINISH:     fin_c        = out_free;
      default:       in_ready_c   = 1'b0;
    endcase
  end

  // Probe hits the first free slot; a free slot is sure to exist once here.
  assign sub_hit_c = sub_probe_c && !valid_r[cnt_r];

  // ---------------------------------------------------------------- shared comparator
  psjq_rank_unit u_rank (
    .policy    (policy_r),
    .cand      (rd_data_r),
    .best      (best_rank_r),
    .cand_rank (cand_rank),
    .better    (cand_better)
  );

  // Take the beat read last cycle if its slot is live and it ranks first so far.
  assign take_cand = dsp_cmp_c && rd_live_r && (!best_found_r || cand_better);

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      policy_r     <= POL_FCFS;
      valid_r      <= '0;
      count_r      <= '0;
      submitted_r  <= '0;
      cnt_r        <= '0;
      rd_live_r    <= 1'b0;
      best_found_r <= 1'b0;
      res_acc_r    <= 1'b0;
      res_dv_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_live_r <= scan_rd_c && valid_r[cnt_r];

      if (cfg_we) policy_r <= cfg_data;

      // Restart the walk and drop the previous item's outcome on a new beat.
      if (in_beat) begin
        cnt_r        <= '0;
        best_found_r <= 1'b0;
        res_acc_r    <= 1'b0;
        res_dv_r     <= 1'b0;
      end else if (scan_rd_c || (sub_probe_c && !sub_hit_c)) begin
        cnt_r <= cnt_r + 1'b1;
      end

      if (take_cand) best_found_r <= 1'b1;

      if (sub_hit_c) begin
        valid_r[cnt_r] <= 1'b1;
        count_r        <= count_r + 1'b1;
        submitted_r    <= submitted_r + 1'b1;
        res_acc_r      <= 1'b1;
      end

      if (dsp_commit_c && best_found_r) begin
        valid_r[best_idx_r] <= 1'b0;
        count_r             <= count_r - 1'b1;
        res_dv_r            <= 1'b1;
      end

      // Output register: load on finish, drop once the sink takes the beat.
      if (fin_c) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- slot memory
  always_ff @(posedge clk) begin
    if (sub_hit_c) slot_mem_r[cnt_r] <= job_r;
    rd_data_r <= slot_mem_r[cnt_r];
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      job_r.tag     <= in_ch.job_tag;
      job_r.arrival <= in_ch.arrival_stamp;
      job_r.runtime <= in_ch.expected_time;
      job_r.prio    <= in_ch.job_priority;
    end

    rd_idx_r <= cnt_r;

    if (take_cand) begin
      best_rank_r <= cand_rank;
      best_idx_r  <= rd_idx_r;
      best_job_r  <= rd_data_r;
    end

    // Job fields mean something only for a dispatch that found a job.
    if (fin_c) begin
      out_acc_r  <= res_acc_r;
      out_dv_r   <= res_dv_r;
      out_tag_r  <= res_dv_r ? best_job_r.tag     : '0;
      out_exp_r  <= res_dv_r ? best_job_r.runtime : '0;
      out_pri_r  <= res_dv_r ? best_job_r.prio    : '0;
      out_qcnt_r <= QCNT_W'(count_r);
      out_tot_r  <= submitted_r;
    end
  end

  // ---------------------------------------------------------------- ports
  assign in_ch.ready            = in_ready_c;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.accepted        = out_acc_r;
  assign out_ch.dispatch_valid  = out_dv_r;
  assign out_ch.out_tag         = out_tag_r;
  assign out_ch.out_expected    = out_exp_r;
  assign out_ch.out_priority    = out_pri_r;
  assign out_ch.queue_count     = out_qcnt_r;
  assign out_ch.submitted_total = out_tot_r;

  // ---------------------------------------------------------------- assertions
  `PSJQ_ASSERT_NOW(a_count_tracks_valid, 1'b1, $countones(valid_r) == count_r, "job count disagrees with valid slots")
  `PSJQ_ASSERT_NOW(a_count_bounded, 1'b1, count_r <= CNT_W'(QUEUE_DEPTH), "job count above table depth")
  `PSJQ_ASSERT_NEXT(a_commit_frees_slot, dsp_commit_c && best_found_r, !valid_r[$past(best_idx_r)], "dispatched slot still valid")
  `PSJQ_ASSERT_NOW(a_one_outcome, out_valid_r, !(out_acc_r && out_dv_r), "result both accepted and dispatched")

endmodule
